@@ hw/rtl/cmd_pkg.sv @@
// Shared types and constants for the control message dispatcher.
package cmd_pkg;

  localparam int unsigned CaptureBytes = 16;
  localparam logic [16:0] CountMax = 17'h1FFFF;
  localparam logic [15:0] RangeLimitReset = 16'd10000;

  typedef enum logic [3:0] {
    ActMalformed  = 4'd0,
    ActRetransmit = 4'd1,
    ActRun        = 4'd2,
    ActEcho       = 4'd3,
    ActRtt        = 4'd4,
    ActKeepalive  = 4'd5,
    ActFlow       = 4'd6,
    ActNonce      = 4'd7,
    ActRemoteUns  = 4'd8,
    ActUnsupReply = 4'd9,
    ActNone       = 4'd10
  } action_e;

  localparam logic [15:0] IdxNackMask  = 16'h0000;
  localparam logic [15:0] IdxNackRange = 16'h0001;
  localparam logic [15:0] IdxEchoReq   = 16'h0010;
  localparam logic [15:0] IdxEchoResp  = 16'h0011;
  localparam logic [15:0] IdxKeepalive = 16'h8000;
  localparam logic [15:0] IdxFlowAttr  = 16'h8001;
  localparam logic [15:0] IdxNonce     = 16'h8011;
  localparam logic [15:0] IdxUnsupp    = 16'h8020;

  localparam logic [2:0] RegSender   = 3'd0;
  localparam logic [2:0] RegReceiver = 3'd1;
  localparam logic [2:0] RegEvenKey  = 3'd2;
  localparam logic [2:0] RegOddKey   = 3'd3;
  localparam logic [2:0] RegRange    = 3'd4;

  typedef enum logic [2:0] {
    StCollect,
    StDecode,
    StRtt1,
    StRtt2,
    StEmit,
    StMask
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic take_byte;   // absorb accepted byte
    logic decode;      // latch first result of the message
    logic rtt_mul;     // register RTT product
    logic rtt_fin;     // finish RTT value
    logic mask_load;   // load NACK mask for the scan
    logic mask_step;   // present next set mask bit
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_rtt;
    logic is_mask;     // a NACK mask burst follows the first result
    logic mask_any;    // scan bits remain
  } sts_t;

endpackage

@@ hw/rtl/cmd_ctrl.sv @@
// Controller state machine of the control message dispatcher.
module cmd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            in_last_i,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  input  cmd_pkg::sts_t   sts_i,
  output cmd_pkg::cmd_t   cmd_o
);

  cmd_pkg::state_e state_q, state_d;
  logic acc, take;

  assign acc  = in_valid_i && in_ready_o;
  assign take = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cmd_pkg::StCollect;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      cmd_pkg::StCollect: begin
        if (acc && in_last_i) begin
          state_d = cmd_pkg::StDecode;
        end
      end
      cmd_pkg::StDecode: state_d = cmd_pkg::StEmit;
      cmd_pkg::StRtt1: state_d = cmd_pkg::StRtt2;
      cmd_pkg::StRtt2: state_d = cmd_pkg::StEmit;
      cmd_pkg::StEmit: begin
        if (sts_i.is_rtt) begin
          state_d = cmd_pkg::StRtt1;
        end else if (take) begin
          state_d = sts_i.is_mask ? cmd_pkg::StMask : cmd_pkg::StCollect;
        end
      end
      cmd_pkg::StMask: begin
        if (take && !sts_i.mask_any) begin
          state_d = cmd_pkg::StCollect;
        end
      end
      default: state_d = cmd_pkg::StCollect;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      cmd_pkg::StCollect: begin
        in_ready_o      = 1'b1;
        cmd_o.take_byte = acc;
      end
      cmd_pkg::StDecode: begin
        cmd_o.decode    = 1'b1;
        cmd_o.mask_load = 1'b1;
      end
      cmd_pkg::StRtt1: cmd_o.rtt_mul = 1'b1;
      cmd_pkg::StRtt2: cmd_o.rtt_fin = 1'b1;
      cmd_pkg::StEmit: begin
        out_valid_o     = !sts_i.is_rtt;
        cmd_o.mask_step = take && sts_i.is_mask;
      end
      cmd_pkg::StMask: begin
        out_valid_o     = 1'b1;
        cmd_o.mask_step = take && sts_i.mask_any;
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/cmd_dpath.sv @@
// Datapath: header capture, body store, decode and result registers.
module cmd_dpath #(
  parameter int unsigned CAPTURE_BYTES = cmd_pkg::CaptureBytes
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmd_pkg::cmd_t   cmd_i,
  output cmd_pkg::sts_t   sts_o,
  input  logic [7:0]      data_byte_i,
  input  logic [63:0]     now_time_i,
  input  logic            sender_q_i,
  input  logic            receiver_q_i,
  input  logic            even_q_i,
  input  logic            odd_q_i,
  input  logic [15:0]     range_limit_i,
  output logic [3:0]      action_o,
  output logic [31:0]     seq_or_index_o,
  output logic [15:0]     run_length_o,
  output logic [31:0]     source_id_o,
  output logic [31:0]     word_high_o,
  output logic [31:0]     word_low_o,
  output logic [63:0]     wide_value_o,
  output logic            flag_o,
  output logic            failed_o,
  output logic            last_result_o
);

  localparam int unsigned AW = $clog2(CAPTURE_BYTES);

  logic [16:0] cnt_q;
  logic [15:0] idx_q, blen_q;
  logic [63:0] now_q;
  logic [7:0]  store_q [CAPTURE_BYTES];
  logic [16:0] total;
  logic [16:0] body_pos;

  assign body_pos = cnt_q - 17'd4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      idx_q  <= '0;
      blen_q <= '0;
      now_q  <= '0;
    end else if (cmd_i.decode) begin
      cnt_q <= '0;
    end else if (cmd_i.take_byte) begin
      case (cnt_q)
        17'd0: idx_q[15:8]  <= data_byte_i;
        17'd1: idx_q[7:0]   <= data_byte_i;
        17'd2: blen_q[15:8] <= data_byte_i;
        17'd3: blen_q[7:0]  <= data_byte_i;
        default: ;
      endcase
      now_q <= now_time_i;
      if (cnt_q != cmd_pkg::CountMax) begin
        cnt_q <= cnt_q + 17'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte && cnt_q >= 17'd4 && body_pos < 17'(CAPTURE_BYTES)) begin
      store_q[body_pos[AW-1:0]] <= data_byte_i;
    end
  end

  function automatic logic [31:0] wd(input logic [7:0] s [CAPTURE_BYTES],
                                     input int unsigned p);
    logic [31:0] w;
    w = '0;
    for (int k = 0; k < 4; k++) begin
      w = {w[23:0], (p + k < CAPTURE_BYTES) ? s[p + k] : 8'h00};
    end
    return w;
  endfunction

  // count including the last byte; decode runs the cycle after it
  assign total = cnt_q;

  logic [3:0]  act_d;
  logic [31:0] seq_d, src_d, hi_d, lo_d;
  logic [15:0] run_d;
  logic [63:0] wide_d;
  logic        flag_d, fail_d, rtt_d, mask_d;
  logic [31:0] w8;
  logic [16:0] want;
  logic [15:0] rcnt;
  logic [47:0] six;
  logic        odd_b, loaded;
  logic        bad;

  assign w8 = wd(store_q, 8);

  always_comb begin
    act_d = cmd_pkg::ActMalformed;
    seq_d = '0; src_d = '0; hi_d = '0; lo_d = '0; run_d = '0; wide_d = '0;
    flag_d = 1'b0; fail_d = 1'b0; rtt_d = 1'b0; mask_d = 1'b0;
    // a count above 16 bits always exceeds the limit
    want   = (w8[31:16] != 16'h0) ? 17'h1FFFF : {1'b0, w8[15:0]} + 17'd1;
    rcnt   = (want < {1'b0, range_limit_i}) ? want[15:0] : range_limit_i;
    odd_b  = store_q[0][7];
    loaded = odd_b ? odd_q_i : even_q_i;
    six    = '0;
    for (int i = 0; i < 6; i++) begin
      six = {six[39:0], (16'(i) < blen_q) ? store_q[i] : 8'h00};
    end
    bad = (total < 17'd4) || ({1'b0, blen_q} + 17'd4 > total);
    if (bad) begin
      fail_d = 1'b1;
    end else begin
      case (idx_q)
        cmd_pkg::IdxNackMask: begin
          if (blen_q < 16'd12) fail_d = 1'b1;
          else if (sender_q_i) begin
            act_d = cmd_pkg::ActRetransmit; seq_d = wd(store_q, 4);
            mask_d = 1'b1;
          end else act_d = cmd_pkg::ActNone;
        end
        cmd_pkg::IdxNackRange: begin
          if (blen_q < 16'd12) fail_d = 1'b1;
          else if (sender_q_i && rcnt != 16'd0) begin
            act_d = cmd_pkg::ActRun; seq_d = wd(store_q, 4); run_d = rcnt;
          end else act_d = cmd_pkg::ActNone;
        end
        cmd_pkg::IdxEchoReq: begin
          if (blen_q < 16'd16) fail_d = 1'b1;
          else begin
            act_d = cmd_pkg::ActEcho; src_d = wd(store_q, 0);
            hi_d = wd(store_q, 4); lo_d = w8;
          end
        end
        cmd_pkg::IdxEchoResp: begin
          if (blen_q < 16'd16) fail_d = 1'b1;
          else begin
            act_d = cmd_pkg::ActRtt; rtt_d = 1'b1;
            wide_d = now_q - {wd(store_q, 4), w8};
          end
        end
        cmd_pkg::IdxKeepalive: begin
          if (blen_q < 16'd10) fail_d = 1'b1;
          else begin
            act_d = cmd_pkg::ActKeepalive; wide_d = now_q;
            flag_d = store_q[6][7];
          end
        end
        cmd_pkg::IdxFlowAttr: begin
          if (blen_q != 16'd0 && receiver_q_i) begin
            act_d = cmd_pkg::ActFlow; run_d = blen_q;
          end else act_d = cmd_pkg::ActNone;
        end
        cmd_pkg::IdxNonce: begin
          if (blen_q < 16'd8) fail_d = 1'b1;
          else if (loaded) begin
            act_d = cmd_pkg::ActNonce; hi_d = wd(store_q, 0);
            lo_d = {16'h0, store_q[4], store_q[5]}; flag_d = odd_b;
          end else act_d = cmd_pkg::ActNone;
        end
        cmd_pkg::IdxUnsupp: begin
          if (blen_q < 16'd8) fail_d = 1'b1;
          else begin
            act_d = cmd_pkg::ActRemoteUns;
            seq_d = {16'h0, store_q[4], store_q[5]};
          end
        end
        default: begin
          act_d = cmd_pkg::ActUnsupReply; seq_d = {16'h0, idx_q};
          wide_d = {16'h0, six}; fail_d = 1'b1;
        end
      endcase
    end
  end

  // result registers and NACK mask scan
  logic [31:0] mask_q, base_q;
  logic [4:0]  pos;
  logic        rtt_q, ismask_q;
  logic [63:0] prod_q;
  logic [31:0] dly_q;
  logic [31:0] rest;

  always_comb begin
    pos = '0;
    for (int i = 31; i >= 0; i--) begin
      if (mask_q[i]) pos = 5'(i);
    end
  end
  assign rest = mask_q & ~(32'h1 << pos);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rtt_q    <= 1'b0;
      ismask_q <= 1'b0;
      mask_q   <= '0;
    end else begin
      if (cmd_i.decode) begin
        rtt_q    <= rtt_d;
        ismask_q <= mask_d;
      end
      if (cmd_i.rtt_fin) rtt_q <= 1'b0;
      if (cmd_i.mask_load) mask_q <= w8;
      else if (cmd_i.mask_step && mask_q != 32'h0) mask_q <= rest;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decode) begin
      action_o <= act_d; seq_or_index_o <= seq_d; run_length_o <= run_d;
      source_id_o <= src_d; word_high_o <= hi_d; word_low_o <= lo_d;
      wide_value_o <= wide_d; flag_o <= flag_d; failed_o <= fail_d;
      last_result_o <= !mask_d || (w8 == 32'h0);
      dly_q <= wd(store_q, 12);
      base_q <= wd(store_q, 4);
    end
    if (cmd_i.rtt_mul) begin
      prod_q <= wide_value_o * 64'd1000000;
    end
    if (cmd_i.rtt_fin) begin
      wide_value_o <= {16'h0, prod_q[63:16]} - {32'h0, dly_q};
    end
    if (cmd_i.mask_step) begin
      seq_or_index_o <= base_q + 32'd1 + {27'h0, pos};
      last_result_o  <= (rest == 32'h0);
    end
  end

  assign sts_o.is_rtt   = rtt_q;
  assign sts_o.is_mask  = ismask_q && !last_result_o;
  assign sts_o.mask_any = (mask_q != 32'h0);

endmodule

@@ hw/rtl/control_message_dispatcher_unit.sv @@
// Top level of the control message dispatcher.
// Takes a control payload one byte per accepted request and, at the byte
// marked last, emits one result (or up to 33 for a NACK bitmask). Payload
// bytes are taken one per cycle. After the last byte the input stalls for
// the decode state plus the burst: each result leaves when the sink is
// ready, and the next byte is taken the cycle after the final result
// leaves. Before its result is valid, the RTT reply passes through a status
// check, a 64-bit multiply and a subtract. Configuration writes are taken
// at any time; write only while no message is in flight.
module control_message_dispatcher_unit #(
  parameter int unsigned CAPTURE_BYTES = cmd_pkg::CaptureBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [63:0] now_time_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  action_o,
  output logic [31:0] seq_or_index_o,
  output logic [15:0] run_length_o,
  output logic [31:0] source_id_o,
  output logic [31:0] word_high_o,
  output logic [31:0] word_low_o,
  output logic [63:0] wide_value_o,
  output logic        flag_o,
  output logic        failed_o,
  output logic        last_result_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cmd_pkg::cmd_t cmd;
  cmd_pkg::sts_t sts;
  logic sender_q, receiver_q, even_q, odd_q;
  logic [15:0] range_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sender_q   <= 1'b0;
      receiver_q <= 1'b0;
      even_q     <= 1'b0;
      odd_q      <= 1'b0;
      range_q    <= cmd_pkg::RangeLimitReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cmd_pkg::RegSender:   sender_q   <= cfg_data_i[0];
        cmd_pkg::RegReceiver: receiver_q <= cfg_data_i[0];
        cmd_pkg::RegEvenKey:  even_q     <= cfg_data_i[0];
        cmd_pkg::RegOddKey:   odd_q      <= cfg_data_i[0];
        cmd_pkg::RegRange:    range_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cmd_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .in_last_i(last_byte_i), .out_ready_i, .out_valid_o,
    .sts_i(sts), .cmd_o(cmd)
  );

  cmd_dpath #(.CAPTURE_BYTES(CAPTURE_BYTES)) u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .data_byte_i, .now_time_i,
    .sender_q_i(sender_q), .receiver_q_i(receiver_q),
    .even_q_i(even_q), .odd_q_i(odd_q), .range_limit_i(range_q),
    .action_o, .seq_or_index_o, .run_length_o, .source_id_o,
    .word_high_o, .word_low_o, .wide_value_o, .flag_o, .failed_o,
    .last_result_o
  );

endmodule
